[hw/rtl/napp_pkg.sv]
// ----------------------------------------------------------------------------
// napp_pkg
// Shared constants, register codes and an arithmetic helper for the
// neighbour average pixel predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package napp_pkg;

    // Widths fixed by the stream and register formats.
    localparam int SAMPLE_W   = 8;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH = 2'd1;

    // Register reset values and limits.
    localparam int WIDTH_MIN   = 2;
    localparam int WIDTH_RESET = 640;

    // Mode codes.
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // Floor of a three-neighbour sum (at most 765) divided by three, done as a
    // multiplication by the reciprocal 683/2048, which is exact below 2048.
    function automatic logic [SAMPLE_W-1:0] div3(input logic [9:0] sum);
        logic [19:0] prod;
        prod = {10'd0, sum} * 20'd683;
        return prod[18:11];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/neighbour_average_pixel_predictor_core.sv]
// ----------------------------------------------------------------------------
// neighbour_average_pixel_predictor_core
// Lossless neighbour-average predictor for 8-bit greyscale raster streams,
// turning pixels into residuals (encode) or residuals back into pixels
// (decode), modulo 256.
// ----------------------------------------------------------------------------
// The core takes one sample per cycle unless the output stalls and gives one
// result per sample through the stage B and output registers. Pixels arrive
// in raster order; tuser marks the first pixel of a frame. The previous row
// of rebuilt pixels lives in a line RAM of MAX_WIDTH entries with a
// registered read. Each sample issues a single read, of the above-right
// neighbour, in the cycle of its input transaction; the above neighbour is
// the above-right value of the preceding sample, and column 0 of the line is
// mirrored in a register. When a row of two pixels wraps, the value being
// written is forwarded into the next read. The line RAM is not cleared: the
// first row of a frame does not depend on it. Mode and image width must be
// written through the configuration channel only while the core is idle; the
// core does not enforce this. Widths outside 2..MAX_WIDTH are clamped.
// ----------------------------------------------------------------------------
`default_nettype none

module neighbour_average_pixel_predictor_core #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // Input stream. tdata: sample_in [7:0]. tuser: frame_start [0].
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [napp_pkg::SAMPLE_W-1:0]        s_tdata,
    input  wire logic                                 s_tuser,
    // Result stream. tdata: sample_out [7:0].
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic      [napp_pkg::SAMPLE_W-1:0]        m_tdata,
    // Configuration write channel.
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [napp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [napp_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // Column address width and a width word that can hold MAX_WIDTH itself.
    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int WW0  = $clog2(MAX_WIDTH + 1);
    localparam int WW   = (WW0 > napp_pkg::CFG_DATA_W) ? WW0 : napp_pkg::CFG_DATA_W;
    localparam int WRST = (napp_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                              : napp_pkg::WIDTH_RESET;
    localparam int SW   = napp_pkg::SAMPLE_W;

    // ------------------------------------------------------------------
    // Configuration. The clamped width is worked out once, at the write.
    // ------------------------------------------------------------------
    logic          mode_reg, mode_next;
    logic [WW-1:0] width_reg, width_next;
    logic [WW-1:0] cfg_width_ext;
    logic          cfg_acc;

    assign cfg_ready     = 1'b1;
    assign cfg_acc       = cfg_valid & cfg_ready;
    assign cfg_width_ext = WW'(cfg_data);

    always_comb begin
        mode_next  = mode_reg;
        width_next = width_reg;
        if (cfg_acc) begin
            unique case (cfg_index)
                napp_pkg::CFG_IDX_MODE: begin
                    mode_next = cfg_data[0];
                end
                napp_pkg::CFG_IDX_WIDTH: begin
                    if (cfg_width_ext < WW'(napp_pkg::WIDTH_MIN)) begin
                        width_next = WW'(napp_pkg::WIDTH_MIN);
                    end else if (cfg_width_ext > WW'(MAX_WIDTH)) begin
                        width_next = WW'(MAX_WIDTH);
                    end else begin
                        width_next = cfg_width_ext;
                    end
                end
                default: begin
                    // Indexes beyond the register list are ignored.
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= napp_pkg::MODE_ENCODE;
            width_reg <= WW'(WRST);
        end else begin
            mode_reg  <= mode_next;
            width_reg <= width_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: position tracking at the input transaction. The position of
    // a sample depends only on the tuser flag and the counters, so the line
    // RAM read of the above-right pixel can be issued right away.
    // ------------------------------------------------------------------
    logic          s_acc;
    logic          b_move;
    logic [AW-1:0] col_reg, col_next;
    logic          first_reg, first_next;
    logic          stale;
    logic [AW-1:0] a_x;
    logic          a_first;
    logic          a_last;
    logic [AW-1:0] rd_addr;

    // Pipeline register between stage A and stage B.
    logic          p1_valid_reg, p1_valid_next;
    logic [AW-1:0] p1_x_reg;
    logic          p1_first_reg;
    logic          p1_last_reg;
    logic [SW-1:0] p1_sample_reg;

    // Output register.
    logic          o_valid_reg, o_valid_next;
    logic [SW-1:0] o_data_reg;

    // Forwarding of a write that lands on the address read in the same cycle.
    logic          fwd_hit_reg, fwd_hit_next;
    logic [SW-1:0] fwd_data_reg;

    // Stage B results.
    logic [SW-1:0] pix;
    logic [SW-1:0] result;

    assign b_move   = p1_valid_reg & (~o_valid_reg | m_tready);
    assign s_tready = ~p1_valid_reg | b_move;
    assign s_acc    = s_tvalid & s_tready;

    always_comb begin
        // A column left over from a wider row ends that row: the sample
        // becomes column 0 of a row that is not the first.
        stale   = ~s_tuser & (WW'(col_reg) >= width_reg);
        a_x     = (s_tuser | stale) ? '0 : col_reg;
        a_first = s_tuser ? 1'b1 : (stale ? 1'b0 : first_reg);
        a_last  = (WW'(a_x) == (width_reg - WW'(1)));
        rd_addr = a_x + AW'(1);

        col_next   = col_reg;
        first_next = first_reg;
        if (s_acc) begin
            if (a_last) begin
                col_next   = '0;
                first_next = 1'b0;
            end else begin
                col_next   = a_x + AW'(1);
                first_next = a_first;
            end
        end
    end

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (s_acc) begin
            p1_valid_next = 1'b1;
        end else if (b_move) begin
            p1_valid_next = 1'b0;
        end

        // The flag belongs to the sample in stage B and leaves with it.
        fwd_hit_next = fwd_hit_reg;
        if (s_acc) begin
            fwd_hit_next = b_move && (p1_x_reg == rd_addr);
        end else if (b_move) begin
            fwd_hit_next = 1'b0;
        end

        o_valid_next = o_valid_reg;
        if (b_move) begin
            o_valid_next = 1'b1;
        end else if (m_tready) begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            first_reg    <= 1'b1;
            p1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            o_valid_reg  <= 1'b0;
        end else begin
            col_reg      <= col_next;
            first_reg    <= first_next;
            p1_valid_reg <= p1_valid_next;
            fwd_hit_reg  <= fwd_hit_next;
            o_valid_reg  <= o_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            p1_x_reg      <= a_x;
            p1_first_reg  <= a_first;
            p1_last_reg   <= a_last;
            p1_sample_reg <= s_tdata;
            fwd_data_reg  <= pix;
        end
        if (b_move) begin
            o_data_reg <= result;
        end
    end

    // ------------------------------------------------------------------
    // Line RAM holding the rebuilt pixels of the previous row.
    // ------------------------------------------------------------------
    logic [SW-1:0] ram_rdata;

    napp_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (b_move),
        .waddr (p1_x_reg),
        .wdata (pix),
        .re    (s_acc),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Stage B: prediction, residual or rebuild, and neighbour update.
    // ------------------------------------------------------------------
    logic [SW-1:0] left_reg;
    logic [SW-1:0] upleft_reg;
    logic [SW-1:0] col0_reg;     // mirror of line RAM entry 0
    logic [SW-1:0] aright_reg;   // above-right of the previous sample
    logic [SW-1:0] above_right;
    logic [SW-1:0] above;
    logic          b_x0;
    logic [8:0]    sum2;
    logic [9:0]    sum3;
    logic [9:0]    sum4;
    logic [SW-1:0] pred;

    always_comb begin
        above_right = fwd_hit_reg ? fwd_data_reg : ram_rdata;
        b_x0        = (p1_x_reg == '0);
        above       = b_x0 ? col0_reg : aright_reg;

        sum2 = {1'b0, above} + {1'b0, above_right};
        sum3 = {2'b00, left_reg} + {2'b00, upleft_reg} + {2'b00, above};
        sum4 = sum3 + {2'b00, above_right};

        if (p1_first_reg) begin
            pred = b_x0 ? '0 : left_reg;
        end else if (b_x0) begin
            pred = sum2[8:1];
        end else if (p1_last_reg) begin
            pred = napp_pkg::div3(sum3);
        end else begin
            pred = sum4[9:2];
        end

        if (mode_reg == napp_pkg::MODE_DECODE) begin
            result = p1_sample_reg + pred;
            pix    = result;
        end else begin
            result = p1_sample_reg - pred;
            pix    = p1_sample_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg   <= '0;
            upleft_reg <= '0;
        end else if (b_move) begin
            left_reg   <= pix;
            upleft_reg <= above;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_move) begin
            aright_reg <= above_right;
            if (b_x0) begin
                col0_reg <= pix;
            end
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_data_reg;

`ifndef NO_ASSERTIONS
    // A frame start always lands in stage B as column 0 of a first row.
    a_frame_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_tuser) |=> (p1_valid_reg && p1_first_reg && (p1_x_reg == '0)))
        else $error("frame start not taken as first-row column 0");

    // A stalled stage B keeps its sample and position.
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && !b_move) |=> (p1_valid_reg && $stable(p1_x_reg)
                                       && $stable(p1_sample_reg)))
        else $error("stage B lost its sample while stalled");

    // Every sample that leaves stage B shows up in the output register.
    a_result_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        b_move |=> o_valid_reg)
        else $error("result dropped between stage B and output");

    // Forwarding only ever refers to a sample that is in stage B.
    a_fwd_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_hit_reg |-> p1_valid_reg)
        else $error("forwarding flag set with stage B empty");
`endif

endmodule

`default_nettype wire

[hw/rtl/napp_ram.sv]
// ----------------------------------------------------------------------------
// napp_ram
// Generic single-clock RAM with one write port and one registered read port.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module napp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
